FILE: hw/rtl/tawu_pkg.sv
// Shared types and constants for the TCP ack / send-window update block.
// Sequencer states, ALU opcodes, event codes and register indexes.
// No dependencies.
`default_nettype none

package tawu_pkg;

	localparam int unsigned SEQ_W  = 32;
	localparam int unsigned WND_W  = 16;
	localparam int unsigned DUP_W  = 8;
	localparam int unsigned DIV_W  = WND_W;
	localparam int unsigned CNT_W  = $clog2(DIV_W);
	localparam int unsigned ADDR_W = 4;

	localparam logic [WND_W-1:0] MSS_RESET = 16'd1460;
	localparam logic [WND_W-1:0] WND_RESET = 16'd1460;
	localparam logic [WND_W-1:0] PPW_MIN   = 16'd2;
	localparam logic [DUP_W-1:0] DUP_MAX   = 8'd255;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_SEND_MSS      = 2'd0;
	localparam logic [1:0] REG_INIT_SEND_SEQ = 2'd1;
	localparam logic [1:0] REG_INIT_PEER_SEQ = 2'd2;
	localparam logic [1:0] REG_INIT_SEND_WND = 2'd3;

	localparam logic [1:0] BEYOND_NONE = 2'd0;
	localparam logic [1:0] BEYOND_RST  = 2'd1;
	localparam logic [1:0] BEYOND_ACK  = 2'd2;

	localparam logic [1:0] ACK_EV_NONE = 2'd0;
	localparam logic [1:0] ACK_EV_NEW  = 2'd1;
	localparam logic [1:0] ACK_EV_DUP  = 2'd2;

	localparam logic [1:0] WIN_EV_NONE   = 2'd0;
	localparam logic [1:0] WIN_EV_OPEN   = 2'd1;
	localparam logic [1:0] WIN_EV_CLOSED = 2'd2;

	typedef enum logic [0:0] {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,  // wait for a request
		ST_SEQ,   // seg_seq vs window seq stamp
		ST_ACK,   // ack vs window ack stamp, window update decision
		ST_OWL,   // old window right edge
		ST_WL,    // new window right edge
		ST_WLT,   // new edge before old edge
		ST_OWLT,  // old edge at or before new edge
		ST_NXT,   // pull back send next
		ST_MAX,   // ack beyond send max
		ST_UNA,   // ack advances unacked
		ST_OLD,   // ack older than unacked
		ST_WIN,   // commit
		ST_DIV,   // largest window / mss, one bit per cycle
		ST_PPW,   // clamp quotient
		ST_OUT    // hand result to output register
	} state_t;

	typedef struct packed {
		logic acc;
		logic ack_flag;
		logic upd_ok;
		logic grow;
		logic out_free;
	} seq_stat_t;

	typedef struct packed {
		logic in_ready;
		logic load_out;
	} seq_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tcp_ack_window_update.sv
// Top level of the TCP ack / send-window update block: APB registers,
// connection state, operand selection for the shared ALU, output register.
// Depends on tawu_pkg, tawu_alu and tawu_seq.
//
//  channel  | signals                        | direction | moves
//  ---------+--------------------------------+-----------+---------------------
//  in       | in_valid/in_ready + fields     | sink      | one segment request
//  out      | out_valid/out_ready + fields   | source    | one result per request
//  cfg      | psel/penable/pwrite/paddr/...  | sink      | register write / read
//
// One request at a time. A request without the ACK flag goes straight to the
// output step; with it, the sequencer walks the compare steps, each one pass
// through the single adder, adding the window-update steps when a window update
// is taken and a restoring divide by the MSS on the shared ALU when the largest
// window grows. A result waiting in the output register does not block the next
// request; that request holds in its last step until the register frees. Reset
// clears all connection state to its reset values.
`default_nettype none

module tcp_ack_window_update
	import tawu_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,

	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              ack_flag,
	input  wire logic [SEQ_W-1:0]  seg_seq,
	input  wire logic [SEQ_W-1:0]  ack_number,
	input  wire logic [WND_W-1:0]  adv_window,
	input  wire logic [WND_W-1:0]  seg_length,
	input  wire logic              update_window,
	input  wire logic              in_syn_received,
	input  wire logic [SEQ_W-1:0]  send_max,
	input  wire logic [SEQ_W-1:0]  send_next,

	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   accepted,
	output logic      [1:0]        beyond_reply,
	output logic      [1:0]        ack_event,
	output logic      [1:0]        window_event,
	output logic      [SEQ_W-1:0]  next_send_out,
	output logic      [SEQ_W-1:0]  unacked_out,
	output logic      [DUP_W-1:0]  dup_ack_count,
	output logic      [WND_W-1:0]  packets_per_window
);

	// configuration
	logic [WND_W-1:0] mss_q;
	logic [SEQ_W-1:0] init_send_seq_q;
	logic [SEQ_W-1:0] init_peer_seq_q;
	logic [WND_W-1:0] init_send_wnd_q;

	// connection state
	logic [SEQ_W-1:0] unacked_q;
	logic [WND_W-1:0] wsize_q;
	logic [SEQ_W-1:0] wseq_q;
	logic [SEQ_W-1:0] wack_q;
	logic [WND_W-1:0] largest_q;
	logic [WND_W-1:0] ppw_q;
	logic [DUP_W-1:0] dup_q;

	// latched request
	logic             ack_flag_q;
	logic [SEQ_W-1:0] sseq_q;
	logic [SEQ_W-1:0] ackn_q;
	logic [WND_W-1:0] wnd_q;
	logic [WND_W-1:0] slen_q;
	logic             upd_q;
	logic             synr_q;
	logic [SEQ_W-1:0] smax_q;
	logic [SEQ_W-1:0] nxt_q;

	// step results
	logic             lt_seq_q;
	logic             eq_seq_q;
	logic             upd_ok_q;
	logic [SEQ_W-1:0] owlast_q;
	logic [SEQ_W-1:0] wlast_q;
	logic             shrink_q;
	logic             open_q;
	logic             beyond_q;
	logic             new_q;
	logic             old_q;
	logic [1:0]       bey_q;
	logic [1:0]       aev_q;
	logic [1:0]       wev_q;

	// divider
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W:0]   rem_ext;
	logic [WND_W-1:0] mss_eff;

	// output register
	logic             out_valid_q;
	logic             acc_o_q;
	logic [1:0]       bey_o_q;
	logic [1:0]       aev_o_q;
	logic [1:0]       wev_o_q;
	logic [SEQ_W-1:0] nxt_o_q;
	logic [SEQ_W-1:0] una_o_q;
	logic [DUP_W-1:0] dup_o_q;
	logic [WND_W-1:0] ppw_o_q;

	alu_op_t          alu_op;
	logic [SEQ_W-1:0] alu_a;
	logic [SEQ_W-1:0] alu_b;
	logic [SEQ_W-1:0] alu_sum;
	logic             alu_neg;
	logic             alu_zero;

	state_t           state;
	seq_stat_t        stat;
	seq_ctl_t         ctl;

	logic             cfg_wr;
	logic             in_acc;
	logic             upd_ok_c;
	logic             grow_c;

	assign cfg_wr   = psel && penable && pwrite;
	assign pready   = 1'b1;
	assign in_ready = ctl.in_ready;
	assign in_acc   = in_valid && ctl.in_ready;
	assign mss_eff  = (mss_q == '0) ? WND_W'(1) : mss_q;
	assign rem_ext  = {rem_q, quo_q[DIV_W-1]};

	assign upd_ok_c = upd_q && !(lt_seq_q || (eq_seq_q && alu_neg));
	assign grow_c   = upd_ok_q && (wnd_q > largest_q);

	always_comb begin
		stat.acc      = in_acc;
		stat.ack_flag = ack_flag;
		stat.upd_ok   = upd_ok_c;
		stat.grow     = grow_c;
		stat.out_free = !out_valid_q || out_ready;
	end

	always_comb begin
		case (paddr[3:2])
			REG_SEND_MSS:      prdata = {16'd0, mss_q};
			REG_INIT_SEND_SEQ: prdata = init_send_seq_q;
			REG_INIT_PEER_SEQ: prdata = init_peer_seq_q;
			REG_INIT_SEND_WND: prdata = {16'd0, init_send_wnd_q};
			default:           prdata = '0;
		endcase
	end

	// operand selection for the shared unit
	always_comb begin
		alu_op = ALU_SUB;
		alu_a  = '0;
		alu_b  = '0;
		case (state)
			ST_SEQ: begin
				alu_a = sseq_q;
				alu_b = wseq_q;
			end
			ST_ACK: begin
				alu_a = ackn_q;
				alu_b = wack_q;
			end
			ST_OWL: begin
				alu_op = ALU_ADD;
				alu_a  = wack_q;
				alu_b  = {16'd0, wsize_q};
			end
			ST_WL: begin
				alu_op = ALU_ADD;
				alu_a  = ackn_q;
				alu_b  = {16'd0, wnd_q};
			end
			ST_WLT: begin
				alu_a = wlast_q;
				alu_b = owlast_q;
			end
			ST_OWLT: begin
				alu_a = owlast_q;
				alu_b = wlast_q;
			end
			ST_NXT: begin
				alu_a = wlast_q;
				alu_b = nxt_q;
			end
			ST_MAX: begin
				alu_a = smax_q;
				alu_b = ackn_q;
			end
			ST_UNA: begin
				alu_a = unacked_q;
				alu_b = ackn_q;
			end
			ST_OLD: begin
				alu_a = ackn_q;
				alu_b = unacked_q;
			end
			ST_DIV: begin
				alu_a = {15'd0, rem_ext};
				alu_b = {16'd0, mss_eff};
			end
			default: begin
				alu_op = ALU_SUB;
			end
		endcase
	end

	tawu_alu u_alu (
		.op   (alu_op),
		.a    (alu_a),
		.b    (alu_b),
		.sum  (alu_sum),
		.neg  (alu_neg),
		.zero (alu_zero)
	);

	tawu_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.state  (state),
		.ctl    (ctl)
	);

	// request latch and per-step flags
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ack_flag_q <= ack_flag;
			sseq_q     <= seg_seq;
			ackn_q     <= ack_number;
			wnd_q      <= adv_window;
			slen_q     <= seg_length;
			upd_q      <= update_window;
			synr_q     <= in_syn_received;
			smax_q     <= send_max;
			nxt_q      <= send_next;
		end else if (state == ST_NXT && shrink_q && alu_neg) begin
			nxt_q <= wlast_q;
		end
		case (state)
			ST_SEQ: begin
				lt_seq_q <= alu_neg;
				eq_seq_q <= alu_zero;
			end
			ST_OWL:  owlast_q <= alu_sum;
			ST_WL:   wlast_q  <= alu_sum;
			ST_WLT:  shrink_q <= alu_neg;
			ST_OWLT: open_q   <= alu_neg || alu_zero;
			ST_MAX:  beyond_q <= alu_neg;
			ST_UNA:  new_q    <= alu_neg;
			ST_OLD:  old_q    <= alu_neg;
			default: ;
		endcase
	end

	// divider: restoring, one quotient bit a cycle through the shared unit
	always_ff @(posedge clk) begin
		if (state == ST_WIN) begin
			rem_q <= '0;
			quo_q <= wnd_q;
		end else if (state == ST_DIV) begin
			if (!alu_neg) begin
				rem_q <= alu_sum[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_ext[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	// configuration and connection state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mss_q           <= MSS_RESET;
			init_send_seq_q <= '0;
			init_peer_seq_q <= '0;
			init_send_wnd_q <= WND_RESET;
			unacked_q       <= '0;
			wsize_q         <= WND_RESET;
			wseq_q          <= '0;
			wack_q          <= '0;
			largest_q       <= '0;
			ppw_q           <= '0;
			dup_q           <= '0;
			upd_ok_q        <= 1'b0;
			bey_q           <= BEYOND_NONE;
			aev_q           <= ACK_EV_NONE;
			wev_q           <= WIN_EV_NONE;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_SEND_MSS: mss_q <= pwdata[WND_W-1:0];
				REG_INIT_SEND_SEQ: begin
					init_send_seq_q <= pwdata;
					unacked_q       <= pwdata;
					wack_q          <= pwdata;
				end
				REG_INIT_PEER_SEQ: begin
					init_peer_seq_q <= pwdata;
					wseq_q          <= pwdata;
				end
				REG_INIT_SEND_WND: begin
					init_send_wnd_q <= pwdata[WND_W-1:0];
					wsize_q         <= pwdata[WND_W-1:0];
				end
				default: ;
			endcase
		end else begin
			if (in_acc) begin
				upd_ok_q <= 1'b0;
				bey_q    <= BEYOND_NONE;
				aev_q    <= ACK_EV_NONE;
				wev_q    <= WIN_EV_NONE;
			end
			if (state == ST_ACK) begin
				upd_ok_q <= upd_ok_c;
			end
			if (state == ST_WIN) begin
				if (upd_ok_q) begin
					wsize_q <= wnd_q;
					wseq_q  <= sseq_q;
					wack_q  <= ackn_q;
					wev_q   <= (open_q && wnd_q != '0) ? WIN_EV_OPEN : WIN_EV_CLOSED;
					if (grow_c) begin
						largest_q <= wnd_q;
					end
				end
				if (beyond_q) begin
					bey_q <= synr_q ? BEYOND_RST : BEYOND_ACK;
				end else if (new_q) begin
					unacked_q <= ackn_q;
					dup_q     <= '0;
					aev_q     <= ACK_EV_NEW;
				end else if (old_q) begin
					aev_q <= ACK_EV_NONE;
				end else if (wsize_q == wnd_q && slen_q == '0) begin
					if (dup_q != DUP_MAX) begin
						dup_q <= dup_q + 1'b1;
					end
					aev_q <= ACK_EV_DUP;
				end
			end
			if (state == ST_PPW) begin
				ppw_q <= (quo_q < PPW_MIN) ? PPW_MIN : quo_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			acc_o_q <= ack_flag_q;
			bey_o_q <= bey_q;
			aev_o_q <= aev_q;
			wev_o_q <= wev_q;
			nxt_o_q <= nxt_q;
			una_o_q <= unacked_q;
			dup_o_q <= dup_q;
			ppw_o_q <= ppw_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign accepted           = acc_o_q;
	assign beyond_reply       = bey_o_q;
	assign ack_event          = aev_o_q;
	assign window_event       = wev_o_q;
	assign next_send_out      = nxt_o_q;
	assign unacked_out        = una_o_q;
	assign dup_ack_count      = dup_o_q;
	assign packets_per_window = ppw_o_q;

`ifndef ASSERT_OFF
	// a saturated duplicate count only holds or restarts on a new ack
	a_dup_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(dup_q == DUP_MAX) |=> (dup_q == DUP_MAX || dup_q == '0))
		else $error("dup count left saturation without reset");

	// packets per window is either untouched or clamped to the minimum
	a_ppw_min: assert property (@(posedge clk) disable iff (!arst_n)
		(ppw_q == '0 || ppw_q >= PPW_MIN))
		else $error("packets per window below minimum");

	// the largest window seen never shrinks
	a_largest_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (largest_q >= $past(largest_q)))
		else $error("largest window decreased");

	// divider remainder stays below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state == ST_DIV) |-> (rem_q < mss_eff))
		else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/tawu_alu.sv
// Shared 32-bit add/subtract unit with sign and zero flags.
// All modulo-2^32 sequence compares and the divider steps go through it.
// Depends on tawu_pkg.
`default_nettype none

module tawu_alu
	import tawu_pkg::*;
(
	input  wire alu_op_t          op,
	input  wire logic [SEQ_W-1:0] a,
	input  wire logic [SEQ_W-1:0] b,
	output logic      [SEQ_W-1:0] sum,
	output logic                  neg,
	output logic                  zero
);

	always_comb begin
		if (op == ALU_SUB) begin
			sum = a - b;
		end else begin
			sum = a + b;
		end
		neg  = sum[SEQ_W-1];
		zero = (sum == '0);
	end

endmodule

`default_nettype wire

FILE: hw/rtl/tawu_seq.sv
// Step sequencer for the ack / window update block.
// Walks the compare steps, runs the divide count, holds for the output register.
// Depends on tawu_pkg.
`default_nettype none

module tawu_seq
	import tawu_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire seq_stat_t stat,
	output state_t         state,
	output seq_ctl_t       ctl
);

	state_t           state_q;
	state_t           state_nxt;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_WIN) begin
				cnt_q <= CNT_W'(DIV_W - 1);
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (stat.acc) begin
					state_nxt = stat.ack_flag ? ST_SEQ : ST_OUT;
				end
			end
			ST_SEQ:  state_nxt = ST_ACK;
			ST_ACK:  state_nxt = stat.upd_ok ? ST_OWL : ST_MAX;
			ST_OWL:  state_nxt = ST_WL;
			ST_WL:   state_nxt = ST_WLT;
			ST_WLT:  state_nxt = ST_OWLT;
			ST_OWLT: state_nxt = ST_NXT;
			ST_NXT:  state_nxt = ST_MAX;
			ST_MAX:  state_nxt = ST_UNA;
			ST_UNA:  state_nxt = ST_OLD;
			ST_OLD:  state_nxt = ST_WIN;
			ST_WIN:  state_nxt = stat.grow ? ST_DIV : ST_OUT;
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_nxt = ST_PPW;
				end
			end
			ST_PPW:  state_nxt = ST_OUT;
			ST_OUT: begin
				if (stat.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.in_ready = (state_q == ST_IDLE);
		ctl.load_out = (state_q == ST_OUT) && stat.out_free;
	end

	assign state = state_q;

endmodule

`default_nettype wire
